@@ sv/pfre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfre_pkg
// Shared constants, codes and payload types of the page frame replacement
// engine.
// ----------------------------------------------------------------------------
package pfre_pkg;

	localparam int FRAMES     = 16;
	localparam int SWAP_SLOTS = 16;
	localparam int PAGE_W     = 19;
	localparam int IDX_W      = 4;
	localparam int FI_W       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int SI_W       = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
	localparam int CNT_W      = $clog2(FRAMES + 1);
	localparam int SCAN_N     = (FRAMES > SWAP_SLOTS) ? FRAMES : SWAP_SLOTS;
	localparam int SC_W       = $clog2(SCAN_N + 1);

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FAULT   = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_ACCESS  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_EVICT     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_SWAP_FULL = 3'd3,
		ST_FEW_RES   = 3'd4
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [PAGE_W-1:0]  page_number;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   frame_index;
		logic               victim_valid;
		logic [PAGE_W-1:0]  victim_page;
		logic [IDX_W-1:0]   swap_slot;
	} rsp_t;

endpackage

@@ sv/pfre_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfre_if
// Valid/ready channels of the engine: request, response and policy write.
// ----------------------------------------------------------------------------
interface pfre_req_if import pfre_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfre_rsp_if import pfre_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfre_cfg_if ();
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/page_frame_replacement_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_replacement_engine
// Resident frame and swap slot bookkeeping with FIFO or second chance victim
// selection; page numbers live in two single-port-read synchronous memories.
// ----------------------------------------------------------------------------
// Channel  Dir  Transaction
// req      in   mode, page_number: one operation
// rsp      out  status, frame_index, victim_valid, victim_page, swap_slot
// cfg      in   policy bit (0 FIFO, 1 second chance)
//
// One operation at a time. An allocate with a free frame, or any refused at
// acceptance, goes straight to the final step. Lookups scan both memories
// one entry a cycle. An eviction passes each referenced frame (up to 16),
// then reads the victim page. Reset clears all valid bits at once; no sweep.
// A waiting response holds the next request back only at its final step.
// ----------------------------------------------------------------------------
module page_frame_replacement_engine import pfre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pfre_req_if.sink    req,
	pfre_rsp_if.source  rsp,
	pfre_cfg_if.sink    cfg
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_VICTIM = 6'b001000,
		S_VREAD  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t             state_q;
	logic               policy_q;
	logic [FRAMES-1:0]  used_q;
	logic [FRAMES-1:0]  ref_q;
	logic [FI_W-1:0]    rank_q [FRAMES];
	logic [CNT_W-1:0]   rc_q;
	logic [SWAP_SLOTS-1:0] slot_used_q;

	logic [PAGE_W-1:0]  frame_mem [FRAMES];
	logic [PAGE_W-1:0]  slot_mem [SWAP_SLOTS];
	logic [PAGE_W-1:0]  frame_rdata_q;
	logic [PAGE_W-1:0]  slot_rdata_q;
	logic [FI_W-1:0]    frame_raddr;

	mode_t              mode_q;
	logic [PAGE_W-1:0]  page_q;
	logic [SC_W-1:0]    scan_cnt_q;
	logic               rd_vld_s1;
	logic [SC_W-1:0]    rd_idx_s1;
	logic               fhit_q;
	logic [FI_W-1:0]    fhit_idx_q;
	logic               shit_q;
	logic [SI_W-1:0]    shit_idx_q;
	logic [FI_W-1:0]    victim_q;
	logic [SI_W-1:0]    slot_sel_q;
	rsp_t               res_q;
	logic               rsp_valid_q;
	rsp_t               rsp_data_q;

	logic               acc;
	logic               any_free;
	logic [FI_W-1:0]    free_idx;
	logic               any_slot;
	logic [SI_W-1:0]    slot_idx;
	logic [FI_W-1:0]    old_idx;
	logic [FI_W-1:0]    rank_top;
	rsp_t               acc_res;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
	assign acc       = req.valid && req.ready;
	assign rank_top  = FI_W'(rc_q - CNT_W'(1));

	// Find lowest free frame and slot, and the oldest resident frame
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		any_slot = 1'b0;
		slot_idx = '0;
		old_idx  = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free = 1'b1;
				free_idx = FI_W'(i);
			end
		end
		for (int i = SWAP_SLOTS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				any_slot = 1'b1;
				slot_idx = SI_W'(i);
			end
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (used_q[i] && rank_q[i] == rank_top) begin
				old_idx = FI_W'(i);
			end
		end
	end

	// Form the response of an operation settled at acceptance
	always_comb begin
		acc_res = '0;
		if (req.data.mode == MODE_ALLOC) begin
			if (any_free) begin
				acc_res.frame_index = IDX_W'(free_idx);
			end else if (!any_slot) begin
				acc_res.status = ST_SWAP_FULL;
			end else if (rc_q < CNT_W'(2)) begin
				acc_res.status = ST_FEW_RES;
			end
		end else if (req.data.mode == MODE_FAULT && rc_q < CNT_W'(2)) begin
			acc_res.status = ST_FEW_RES;
		end
	end

	// Select the frame memory read address
	always_comb begin
		if (state_q == S_VICTIM) begin
			frame_raddr = old_idx;
		end else begin
			frame_raddr = scan_cnt_q[FI_W-1:0];
		end
	end

	// Page memories: one read and one write per cycle each
	always_ff @(posedge clk) begin
		frame_rdata_q <= frame_mem[frame_raddr];
		slot_rdata_q  <= slot_mem[scan_cnt_q[SI_W-1:0]];
		if (acc && req.data.mode == MODE_ALLOC && any_free) begin
			frame_mem[free_idx] <= req.data.page_number;
		end else if (state_q == S_VREAD) begin
			frame_mem[victim_q] <= page_q;
		end
		if (state_q == S_VREAD) begin
			slot_mem[slot_sel_q] <= frame_rdata_q;
		end
	end

	// Age ranks: only meaningful for resident frames, no reset
	always_ff @(posedge clk) begin
		if (acc && req.data.mode == MODE_ALLOC && any_free) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (used_q[i]) begin
					rank_q[i] <= rank_q[i] + FI_W'(1);
				end
			end
			rank_q[free_idx] <= '0;
		end else if (state_q == S_VICTIM && policy_q && ref_q[old_idx]) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (used_q[i] && FI_W'(i) != old_idx) begin
					rank_q[i] <= rank_q[i] + FI_W'(1);
				end
			end
			rank_q[old_idx] <= '0;
		end else if (state_q == S_VREAD) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (used_q[i] && FI_W'(i) != victim_q && rank_q[i] < rank_q[victim_q]) begin
					rank_q[i] <= rank_q[i] + FI_W'(1);
				end
			end
			rank_q[victim_q] <= '0;
		end else if (state_q == S_DECIDE && mode_q == MODE_RELEASE && fhit_q) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (used_q[i] && rank_q[i] > rank_q[fhit_idx_q]) begin
					rank_q[i] <= rank_q[i] - FI_W'(1);
				end
			end
			rank_q[fhit_idx_q] <= '0;
		end
	end

	// Payload registers of the operation in flight
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q;
		if (acc) begin
			mode_q <= req.data.mode;
			page_q <= req.data.page_number;
			res_q  <= acc_res;
			if (req.data.mode == MODE_ALLOC) begin
				slot_sel_q <= slot_idx;
			end
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (!fhit_q && rd_idx_s1 < SC_W'(FRAMES) && used_q[rd_idx_s1[FI_W-1:0]]
					&& frame_rdata_q == page_q) begin
				fhit_idx_q <= rd_idx_s1[FI_W-1:0];
			end
			if (!shit_q && rd_idx_s1 < SC_W'(SWAP_SLOTS)
					&& slot_used_q[rd_idx_s1[SI_W-1:0]] && slot_rdata_q == page_q) begin
				shit_idx_q <= rd_idx_s1[SI_W-1:0];
			end
		end
		if (state_q == S_DECIDE) begin
			unique case (mode_q)
				MODE_FAULT: begin
					if (shit_q) begin
						slot_sel_q <= shit_idx_q;
					end else begin
						res_q.status <= ST_NOT_FOUND;
					end
				end
				MODE_RELEASE: begin
					if (fhit_q) begin
						res_q.frame_index <= IDX_W'(fhit_idx_q);
					end else if (shit_q) begin
						res_q.swap_slot <= IDX_W'(shit_idx_q);
					end else begin
						res_q.status <= ST_NOT_FOUND;
					end
				end
				MODE_ACCESS: begin
					if (fhit_q) begin
						res_q.frame_index <= IDX_W'(fhit_idx_q);
					end else begin
						res_q.status <= ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_VICTIM && !(policy_q && ref_q[old_idx])) begin
			victim_q <= old_idx;
		end
		if (state_q == S_VREAD) begin
			res_q.status       <= ST_EVICT;
			res_q.frame_index  <= IDX_W'(victim_q);
			res_q.victim_valid <= 1'b1;
			res_q.victim_page  <= frame_rdata_q;
			res_q.swap_slot    <= IDX_W'(slot_sel_q);
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_data_q <= res_q;
		end
	end

	// Control state, valid bits and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= 1'b1;
			used_q      <= '0;
			ref_q       <= '0;
			rc_q        <= '0;
			slot_used_q <= '0;
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			fhit_q      <= 1'b0;
			shit_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				policy_q <= cfg.data;
			end
			// Load a new response or drop the one taken
			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == S_SCAN) && (scan_cnt_q < SC_W'(SCAN_N));
			unique case (state_q)
				S_IDLE: begin
					scan_cnt_q <= '0;
					fhit_q     <= 1'b0;
					shit_q     <= 1'b0;
					if (acc) begin
						priority case (1'b1)
							req.data.mode == MODE_ALLOC && any_free: begin
								used_q[free_idx] <= 1'b1;
								ref_q[free_idx]  <= 1'b0;
								rc_q             <= rc_q + CNT_W'(1);
								state_q          <= S_FIN;
							end
							req.data.mode == MODE_ALLOC: begin
								state_q <= (any_slot && rc_q >= CNT_W'(2)) ? S_VICTIM : S_FIN;
							end
							req.data.mode == MODE_FAULT && rc_q < CNT_W'(2): begin
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_cnt_q < SC_W'(SCAN_N)) begin
						scan_cnt_q <= scan_cnt_q + SC_W'(1);
					end
					if (rd_vld_s1) begin
						if (rd_idx_s1 < SC_W'(FRAMES) && used_q[rd_idx_s1[FI_W-1:0]]
								&& frame_rdata_q == page_q) begin
							fhit_q <= 1'b1;
						end
						if (rd_idx_s1 < SC_W'(SWAP_SLOTS)
								&& slot_used_q[rd_idx_s1[SI_W-1:0]]
								&& slot_rdata_q == page_q) begin
							shit_q <= 1'b1;
						end
						if (rd_idx_s1 == SC_W'(SCAN_N - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					state_q <= S_FIN;
					if (mode_q == MODE_FAULT && shit_q) begin
						state_q <= S_VICTIM;
					end
					if (mode_q == MODE_RELEASE) begin
						if (fhit_q) begin
							used_q[fhit_idx_q] <= 1'b0;
							ref_q[fhit_idx_q]  <= 1'b0;
							if (rc_q != '0) begin
								rc_q <= rc_q - CNT_W'(1);
							end
						end else if (shit_q) begin
							slot_used_q[shit_idx_q] <= 1'b0;
						end
					end
					if (mode_q == MODE_ACCESS && fhit_q) begin
						ref_q[fhit_idx_q] <= 1'b1;
					end
				end
				S_VICTIM: begin
					// Pass a referenced oldest frame: clear it, make it newest
					if (policy_q && ref_q[old_idx]) begin
						ref_q[old_idx] <= 1'b0;
					end else begin
						state_q <= S_VREAD;
					end
				end
				S_VREAD: begin
					ref_q[victim_q]         <= 1'b0;
					slot_used_q[slot_sel_q] <= 1'b1;
					state_q                 <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/pfre_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfre_checker
// Port-level checks of the response channel, bound to the engine top level.
// ----------------------------------------------------------------------------
module pfre_checker import pfre_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input status_t           rsp_status,
	input logic [IDX_W-1:0]  rsp_frame_index,
	input logic              rsp_victim_valid,
	input logic [PAGE_W-1:0] rsp_victim_page,
	input logic [IDX_W-1:0]  rsp_swap_slot
);

	// Hold a stalled response valid, with its status and victim page
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_victim_page))
		else $error("response changed while stalled");

	// Flag an eviction exactly with its status
	a_evict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_EVICT) == rsp_victim_valid)
		else $error("victim flag disagrees with status");

	// Zero the victim page without an eviction
	a_vpage_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_victim_valid |-> rsp_victim_page == '0)
		else $error("victim page set without eviction");

	// Report no frame or slot on a refused operation
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_SWAP_FULL
			|| rsp_status == ST_FEW_RES)
		|-> rsp_frame_index == '0 && rsp_swap_slot == '0)
		else $error("refused operation names a frame or slot");

endmodule

bind page_frame_replacement_engine pfre_checker u_pfre_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.data.status),
	.rsp_frame_index  (rsp.data.frame_index),
	.rsp_victim_valid (rsp.data.victim_valid),
	.rsp_victim_page  (rsp.data.victim_page),
	.rsp_swap_slot    (rsp.data.swap_slot)
);
